// ===== rtl/hflc_pkg.sv =====
package hflc_pkg;

    // Depth of the descriptor store
    localparam int MaxDescriptors = 64;
    localparam int AddrW          = $clog2(MaxDescriptors);
    localparam int CountW         = $clog2(MaxDescriptors + 1);

    localparam int FieldW = 16;
    localparam int EndW   = FieldW + 1;

    // One stored descriptor: start and exclusive end
    typedef struct packed {
        logic [EndW-1:0]   field_end;
        logic [FieldW-1:0] field_start;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

    // Sequencer state codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

endpackage

// ===== rtl/header_field_layout_checker_top.sv =====
// Channel      | Handshake                 | Payload
// -------------+---------------------------+------------------------------------------
// descriptor   | start, busy               | field_offset, field_length, last_descriptor
// result       | done (one-cycle strobe)   | layout_clean
// capacity cfg | header_capacity_we        | header_capacity_data
//
// While a descriptor is handled busy stays high: the store memory delivers the
// stored entries one per cycle for the overlap compare, then the finish step writes
// new entry unless the store is full, and issues the result on the last descriptor.
// Reset clears the entry count and the violation flag; the store needs no clearing.
// The result beat is shown for one cycle only; the receiver cannot stall it.
module header_field_layout_checker_top
    import hflc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FieldW-1:0] field_offset,
    input  logic [FieldW-1:0] field_length,
    input  logic              last_descriptor,
    output logic              done,
    output logic              layout_clean,
    input  logic              header_capacity_we,
    input  logic [FieldW-1:0] header_capacity_data
);

    logic [1:0]        state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] iss_reg, iss_next;
    logic              rdv_reg;
    logic              viol_reg, viol_next;
    logic [FieldW-1:0] cap_reg;
    logic [FieldW-1:0] start_reg;
    logic [EndW-1:0]   end_reg;
    logic              last_reg;
    logic              done_reg, done_next;
    logic              clean_reg, clean_next;

    logic              accept;
    logic [EndW-1:0]   in_end;
    logic              rd_en;
    logic              wr_en;
    logic              full;
    logic              viol_fin;
    logic              overlap;
    entry_t            rd_data_reg;
    entry_t            wr_data;

    entry_t            store_mem [MaxDescriptors];

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign in_end = {1'b0, field_offset} + {1'b0, field_length};
    assign full   = (count_reg == CountW'(MaxDescriptors));
    assign rd_en  = (state_reg == ST_SCAN) && (iss_reg != count_reg);
    assign wr_en  = (state_reg == ST_FINISH) && !full;

    assign wr_data.field_start = start_reg;
    assign wr_data.field_end   = end_reg;

    // Overlap: each interval starts before the other ends
    assign overlap = ({1'b0, start_reg} < rd_data_reg.field_end)
                  && ({1'b0, rd_data_reg.field_start} < end_reg);

    assign viol_fin = viol_reg || full;

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[AddrW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[iss_reg[AddrW-1:0]];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        iss_next   = iss_reg;
        viol_next  = viol_reg;
        done_next  = 1'b0;
        clean_next = clean_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    iss_next   = '0;
                    state_next = ST_SCAN;
                    if (in_end > {1'b0, cap_reg})
                    begin
                        viol_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // compare the entry read last cycle
                if (rdv_reg && overlap)
                begin
                    viol_next = 1'b1;
                end
                if (rd_en)
                begin
                    iss_next = iss_reg + CountW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                if (last_reg)
                begin
                    done_next  = 1'b1;
                    clean_next = !viol_fin;
                    count_next = '0;
                    viol_next  = 1'b0;
                end
                else
                begin
                    viol_next = viol_fin;
                    if (!full)
                    begin
                        count_next = count_reg + CountW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            iss_reg   <= '0;
            rdv_reg   <= 1'b0;
            viol_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cap_reg   <= '1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            iss_reg   <= iss_next;
            rdv_reg   <= rd_en;
            viol_reg  <= viol_next;
            done_reg  <= done_next;
            if (header_capacity_we)
            begin
                cap_reg <= header_capacity_data;
            end
        end
    end

    // Hold the beat payload and the result value
    always_ff @(posedge clk)
    begin
        clean_reg <= clean_next;
        if (accept)
        begin
            start_reg <= field_offset;
            end_reg   <= in_end;
            last_reg  <= last_descriptor;
        end
    end

    assign done         = done_reg;
    assign layout_clean = clean_reg;

    // Result beat only comes out of the finish step
    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result beat without finish step");

    // Entry count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MaxDescriptors))
        else $error("entry count past store depth");

    // After a result the set state is cleared
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_reg == '0) && !viol_reg)
        else $error("set state not cleared after result");

    // Read data is only flagged valid after a scan cycle
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rdv_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data outside scan");

    // An accepted beat starts a scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_SCAN))
        else $error("accepted beat did not start scan");

endmodule
